FILE: rtl/assert_macros.svh
// concurrent assertion helpers, clocked on aclk, off while aresetn is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define AST_IMPL(lbl, cond, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (prop)) \
        else $error("assertion failed");

// next-cycle implication
`define AST_NEXT(lbl, cond, prop) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (prop)) \
        else $error("assertion failed");

`endif

FILE: rtl/gn1d_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package gn1d_pkg;

    typedef enum logic [1:0] {
        CMD_EVAL = 2'd0,
        CMD_GRAD = 2'd1,
        CMD_PERM = 2'd2
    } cmd_t;

    localparam int STAGES = 8;

    localparam int F_W = 16;
    localparam int G_W = 16;
    localparam int P_W = 8;
    localparam int S_W = 36;
    localparam int A_W = 32;
    localparam int B_W = 33;
    localparam int D_W = 34;
    localparam int U_W = 17;
    localparam int M_W = 52;
    localparam int Y_W = M_W - 32;

    localparam logic [S_W:0] FADE_C10 = (S_W + 1)'(64'd10 << 32);
    localparam logic [S_W:0] FADE_C15 = (S_W + 1)'(15 * 65536);

endpackage

`default_nettype wire

FILE: rtl/gradient_noise_1d.sv
`timescale 1ns / 1ps
`default_nettype none

// One-dimensional gradient noise, one item per clock. An item with tuser 0 evaluates the
// noise at a signed Q16.16 position and gives one Q1.15 result for each one
// accepted; tuser 1 writes a Q1.15 gradient entry and tuser 2 a permutation entry, and
// neither gives a result (tuser 3 is ignored). The eight-stage pipeline takes a new item
// every cycle and stalls as a whole only while a result waits at the output; its depth is
// set by the two table reads (permutation, then gradient, each a two-port registered read)
// and the chain of 36x16 multiplies that builds the quintic fade. A write takes effect for
// every evaluate accepted after it. Both tables must be written before an evaluate reads
// them; entries never written read as arbitrary values. Writes to an index at or above
// TABLE_ENTRIES are dropped, and stored permutation values are reduced modulo TABLE_ENTRIES.

`include "assert_macros.svh"

module gradient_noise_1d #(
    parameter int TABLE_ENTRIES = 256
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // position[31:0], entry_index[39:32], gradient_value[55:40], perm_value[63:56]
    input  wire logic [63:0] s_tdata,
    // cmd[1:0]
    input  wire logic [1:0]  s_tuser,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // noise_value[15:0]
    output logic [15:0]      m_tdata
);

    localparam int IDXW = $clog2(TABLE_ENTRIES);
    localparam logic [IDXW-1:0] IDX_MASK = IDXW'(TABLE_ENTRIES - 1);

    localparam int F_W = gn1d_pkg::F_W;
    localparam int G_W = gn1d_pkg::G_W;
    localparam int P_W = gn1d_pkg::P_W;
    localparam int S_W = gn1d_pkg::S_W;
    localparam int A_W = gn1d_pkg::A_W;
    localparam int B_W = gn1d_pkg::B_W;
    localparam int D_W = gn1d_pkg::D_W;
    localparam int U_W = gn1d_pkg::U_W;
    localparam int M_W = gn1d_pkg::M_W;
    localparam int Y_W = gn1d_pkg::Y_W;
    localparam int STAGES = gn1d_pkg::STAGES;

    // input fields
    gn1d_pkg::cmd_t          cmd;
    logic [31:0]             position;
    logic [7:0]              entry_index;
    logic signed [G_W-1:0]   gradient_value;
    logic [P_W-1:0]          perm_value;

    assign cmd            = gn1d_pkg::cmd_t'(s_tuser);
    assign position       = s_tdata[31:0];
    assign entry_index    = s_tdata[39:32];
    assign gradient_value = s_tdata[55:40];
    assign perm_value     = s_tdata[63:56];

    logic en;
    logic accept;

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;
    assign accept   = s_tvalid && en;

    // tables
    logic [IDXW-1:0]       perm_mem [TABLE_ENTRIES];
    logic signed [G_W-1:0] grad_mem [TABLE_ENTRIES];

    // permutation value modulo table size
    logic [IDXW-1:0] perm_mod [256];

    for (genvar i = 0; i < 256; i++) begin : g_mod
        assign perm_mod[i] = IDXW'(i % TABLE_ENTRIES);
    end

    logic            idx_ok;
    logic [IDXW-1:0] waddr;
    logic [IDXW-1:0] lat0;
    logic [IDXW-1:0] lat1;

    assign idx_ok = 32'(entry_index) < TABLE_ENTRIES;
    assign waddr  = IDXW'(entry_index);
    assign lat0   = position[16 +: IDXW] & IDX_MASK;
    assign lat1   = (position[16 +: IDXW] + IDXW'(1)) & IDX_MASK;

    always_ff @(posedge aclk) begin
        if (accept && idx_ok && cmd == gn1d_pkg::CMD_PERM) begin
            perm_mem[waddr] <= perm_mod[perm_value];
        end
        if (accept && idx_ok && cmd == gn1d_pkg::CMD_GRAD) begin
            grad_mem[waddr] <= gradient_value;
        end
    end

    // valid bits
    logic [STAGES-1:0] vld_reg;
    logic [STAGES-1:0] vld_next;

    always_comb begin
        vld_next = vld_reg;
        if (en) begin
            vld_next = {vld_reg[STAGES-2:0], accept && cmd == gn1d_pkg::CMD_EVAL};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            vld_reg <= vld_next;
        end
    end

    // stage registers
    logic [F_W-1:0]        f1_reg, f2_reg, f3_reg, f4_reg, f5_reg;
    logic [IDXW-1:0]       pi0_reg, pi1_reg;
    logic [31:0]           ff2_reg;
    logic signed [G_W-1:0] g0_reg, g1_reg;
    logic [S_W-1:0]        s0_reg, s1_reg, s2_reg;
    logic signed [A_W-1:0] a3_reg, a4_reg, a5_reg, a6_reg, a7_reg;
    logic signed [B_W-1:0] b3_reg;
    logic signed [D_W-1:0] d4_reg, d5_reg, d6_reg;
    logic [U_W-1:0]        u6_reg;
    logic signed [M_W-1:0] m7_reg;
    logic [15:0]           y8_reg;

    logic [S_W:0]          s0_next;
    logic signed [A_W:0]   a_full;
    logic signed [B_W-1:0] b_next;
    logic [S_W+F_W-1:0]    p1_prod, p2_prod, p3_prod;
    logic [S_W:0]          u_sum;
    logic signed [D_W-1:0] d_next;
    logic signed [M_W-1:0] m_next;
    logic signed [M_W-1:0] r_sum;
    logic signed [Y_W-1:0] y_full;
    logic [15:0]           y_next;

    always_comb begin
        s0_next = (S_W + 1)'(ff2_reg) * (S_W + 1)'(6) + gn1d_pkg::FADE_C10
                  - (S_W + 1)'(f2_reg) * gn1d_pkg::FADE_C15;
        a_full  = $signed({1'b0, f2_reg}) * g0_reg;
        b_next  = $signed({1'b1, f2_reg}) * g1_reg;
        p1_prod = (S_W + F_W)'(s0_reg) * (S_W + F_W)'(f3_reg);
        d_next  = D_W'(b3_reg) - D_W'(a3_reg);
        p2_prod = (S_W + F_W)'(s1_reg) * (S_W + F_W)'(f4_reg);
        p3_prod = (S_W + F_W)'(s2_reg) * (S_W + F_W)'(f5_reg);
        u_sum   = (S_W + 1)'(p3_prod[S_W+F_W-1:F_W]) + (S_W + 1)'(32768);
        m_next  = M_W'($signed({1'b0, u6_reg})) * M_W'(d6_reg);
        r_sum   = (M_W'(a7_reg) <<< 16) + m7_reg + M_W'(64'sd2147483648);
        y_full  = r_sum[M_W-1:32];
        if (y_full > Y_W'(32767)) begin
            y_next = 16'h7fff;
        end else if (y_full < -Y_W'(32768)) begin
            y_next = 16'h8000;
        end else begin
            y_next = y_full[15:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f1_reg  <= position[F_W-1:0];
            pi0_reg <= perm_mem[lat0];
            pi1_reg <= perm_mem[lat1];

            f2_reg  <= f1_reg;
            ff2_reg <= 32'(f1_reg) * 32'(f1_reg);
            g0_reg  <= grad_mem[pi0_reg];
            g1_reg  <= grad_mem[pi1_reg];

            f3_reg  <= f2_reg;
            s0_reg  <= s0_next[S_W-1:0];
            a3_reg  <= a_full[A_W-1:0];
            b3_reg  <= b_next;

            f4_reg  <= f3_reg;
            s1_reg  <= p1_prod[S_W+F_W-1:F_W];
            a4_reg  <= a3_reg;
            d4_reg  <= d_next;

            f5_reg  <= f4_reg;
            s2_reg  <= p2_prod[S_W+F_W-1:F_W];
            a5_reg  <= a4_reg;
            d5_reg  <= d4_reg;

            u6_reg  <= u_sum[U_W+15:16];
            a6_reg  <= a5_reg;
            d6_reg  <= d5_reg;

            m7_reg  <= m_next;
            a7_reg  <= a6_reg;

            y8_reg  <= y_next;
        end
    end

    assign m_tvalid = vld_reg[STAGES-1];
    assign m_tdata  = y8_reg;

    `AST_NEXT(a_write_no_result, accept && cmd != gn1d_pkg::CMD_EVAL, !vld_reg[0])
    `AST_NEXT(a_stall_holds, !s_tready, $stable(vld_reg))
    `AST_IMPL(a_fade_bound, vld_reg[5], u6_reg <= U_W'(65536))

endmodule

`default_nettype wire
